FILE: sv/pat_pkg.sv
// types and codes shared by the pending acknowledgement table
`timescale 1ns / 1ps
`default_nettype none

package pat_pkg;

	localparam logic KIND_RECORD  = 1'b0;
	localparam logic KIND_CONFIRM = 1'b1;

	localparam logic [1:0] STS_RECORDED  = 2'd0;
	localparam logic [1:0] STS_FULL      = 2'd1;
	localparam logic [1:0] STS_CONFIRMED = 2'd2;
	localparam logic [1:0] STS_NOT_FOUND = 2'd3;

	localparam logic [8:0] ACK_OFFSET = 9'd10;

	typedef struct packed {
		logic        kind;
		logic [7:0]  command;
		logic [15:0] sequence_req;
	} pat_req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [5:0] slot;
	} pat_rsp_t;

	typedef struct packed {
		logic        valid;
		logic [7:0]  command;
		logic [15:0] seq_num;
	} pat_entry_t;

endpackage

`default_nettype wire

FILE: sv/pat_mem.sv
// slot memory: one write port, one registered read port
`timescale 1ns / 1ps
`default_nettype none

module pat_mem #(
	parameter int ENTRIES = 64,
	parameter int AW      = 6
) (
	input  wire logic                clk,
	input  wire logic                wr_en,
	input  wire logic [AW-1:0]       wr_addr,
	input  wire pat_pkg::pat_entry_t wr_data,
	input  wire logic                rd_en,
	input  wire logic [AW-1:0]       rd_addr,
	output pat_pkg::pat_entry_t      rd_data
);
	import pat_pkg::*;

	pat_entry_t mem_q [ENTRIES];
	pat_entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

FILE: sv/pat_scan.sv
// scan sequencer: clearing pass, slot search and write-back
`timescale 1ns / 1ps
`default_nettype none

module pat_scan #(
	parameter int ENTRIES = 64,
	parameter int AW      = 6
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire pat_pkg::pat_req_t   request,
	output logic                     busy,
	output logic                     done,
	output pat_pkg::pat_rsp_t        result,
	output logic                     rd_en,
	output logic [AW-1:0]            rd_addr,
	input  wire pat_pkg::pat_entry_t rd_data,
	output logic                     wr_en,
	output logic [AW-1:0]            wr_addr,
	output pat_pkg::pat_entry_t      wr_data
);
	import pat_pkg::*;

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_SCAN  = 2'd2;

	localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

	logic [1:0]    state_q;
	logic [AW-1:0] addr_q;
	logic          done_q;
	pat_req_t      req_q;
	pat_rsp_t      rsp_q;
	pat_rsp_t      rsp_d;
	logic [8:0]    want;
	logic          hit;
	logic          last;
	logic          accept;
	logic          finish;

	assign want   = {1'b0, req_q.command} + ACK_OFFSET;
	assign last   = (addr_q == LAST);
	assign accept = (state_q == ST_IDLE) && start;

	always_comb begin
		if (req_q.kind == KIND_RECORD) begin
			hit = !rd_data.valid;
		end else begin
			hit = rd_data.valid && ({1'b0, rd_data.command} == want)
				&& (rd_data.seq_num == req_q.sequence_req);
		end
	end

	assign finish = (state_q == ST_SCAN) && (hit || last);

	always_comb begin
		if (hit) begin
			rsp_d.status = (req_q.kind == KIND_RECORD) ? STS_RECORDED : STS_CONFIRMED;
			rsp_d.slot   = 6'(addr_q);
		end else begin
			rsp_d.status = (req_q.kind == KIND_RECORD) ? STS_FULL : STS_NOT_FOUND;
			rsp_d.slot   = '0;
		end
	end

	// read next entry while the current one is checked
	assign rd_en   = accept || ((state_q == ST_SCAN) && !hit && !last);
	assign rd_addr = (state_q == ST_IDLE) ? '0 : addr_q + AW'(1);

	assign wr_en   = (state_q == ST_CLEAR) || ((state_q == ST_SCAN) && hit);
	assign wr_addr = addr_q;

	always_comb begin
		if (state_q == ST_CLEAR) begin
			wr_data = '0;
		end else if (req_q.kind == KIND_RECORD) begin
			wr_data.valid   = 1'b1;
			wr_data.command = req_q.command;
			wr_data.seq_num = req_q.sequence_req;
		end else begin
			wr_data.valid   = 1'b0;
			wr_data.command = rd_data.command;
			wr_data.seq_num = rd_data.seq_num;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			addr_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					if (last) begin
						state_q <= ST_IDLE;
						addr_q  <= '0;
					end else begin
						addr_q <= addr_q + AW'(1);
					end
				end
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_SCAN;
						addr_q  <= '0;
					end
				end
				ST_SCAN: begin
					if (hit || last) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end else begin
						addr_q <= addr_q + AW'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= request;
		end
		if (finish) begin
			rsp_q <= rsp_d;
		end
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = rsp_q;

endmodule

`default_nettype wire

FILE: sv/pending_ack_table.sv
// top level of the pending acknowledgement table
// a request is taken when start is high and busy is low; busy then stays high
// while the slot memory is scanned one entry per cycle (one read port)
// done pulses for one cycle with the result when the scan stops at a hit or at the last
// entry, and busy falls with it; the receiver cannot stall
// after reset a clearing pass empties the memory with busy high
`timescale 1ns / 1ps
`default_nettype none

module pending_ack_table #(
	parameter int ENTRIES = 64
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire pat_pkg::pat_req_t request,
	output logic                   busy,
	output logic                   done,
	output pat_pkg::pat_rsp_t      result
);
	import pat_pkg::*;

	localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	logic          rd_en;
	logic [AW-1:0] rd_addr;
	pat_entry_t    rd_data;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	pat_entry_t    wr_data;

	pat_scan #(
		.ENTRIES(ENTRIES),
		.AW     (AW)
	) u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.request(request),
		.busy   (busy),
		.done   (done),
		.result (result),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data)
	);

	pat_mem #(
		.ENTRIES(ENTRIES),
		.AW     (AW)
	) u_mem (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while scan still running");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted request did not start a scan");

	a_miss_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.status == STS_FULL || result.status == STS_NOT_FOUND))
		|-> (result.slot == '0))
		else $error("miss result carries a nonzero slot");

	a_write_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && !busy) |-> 1'b0)
		else $error("memory write outside scan or clearing pass");

endmodule

`default_nettype wire
